// ===== hdl/assert_macros.svh =====
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/ibg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibg_pkg: shared types and constants for the instance batch grouper
// Request and result structs, action and status codes, controller states.
// ----------------------------------------------------------------------------
package ibg_pkg;

	localparam int MaxBatchesDef = 32;
	localparam int ResultLimit = 32;
	localparam logic [15:0] CountMax = 16'hFFFF;
	localparam logic [19:0] TotalMax = 20'hFFFFF;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_SORT = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_NOP = 2'd3;

	localparam logic [2:0] ST_APPEND = 3'd0;
	localparam logic [2:0] ST_NEW = 3'd1;
	localparam logic [2:0] ST_NULL = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_SORTED = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;
	localparam logic [2:0] ST_EMPTY = 3'd6;

	typedef struct packed {
		logic [1:0] action;
		logic [15:0] mesh_id;
		logic [15:0] material_id;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [23:0] cam_x;
		logic signed [23:0] cam_y;
		logic signed [23:0] cam_z;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] batch_index;
		logic [15:0] batch_mesh;
		logic [15:0] batch_material;
		logic [15:0] instance_count;
		logic [51:0] distance_sq;
		logic [19:0] total_instances;
		logic last;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_ADD_END,
		S_DIST,
		S_DIST_WAIT,
		S_SORT_RD,
		S_SORT_CMP,
		S_EMIT_RD,
		S_EMIT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic add_finish;
		logic single_out;
		logic dist_clr;
		logic dist_step;
		logic sort_clr;
		logic sort_rd;
		logic sort_cmp;
		logic emit_clr;
		logic emit_rd;
		logic emit_out;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic scan_done;
		logic dist_done;
		logic sort_done;
		logic shift;
		logic emit_done;
		logic table_empty;
		logic single;
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/instance_batch_grouper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// instance_batch_grouper: draw instance grouping by mesh and material key
// Adds, sorts front to back and clears a table of instance batches.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Results appear on
// result for one cycle each, marked by strobe, and cannot be held off. An add
// scans the table one batch a cycle. A sort runs a distance pass, then an
// insertion sort with a read and a compare step per batch after the first
// plus a compare per shifted entry (at most used*(used-1)/2 shifts), then a
// read and an output step per emitted batch.
module instance_batch_grouper #(
	parameter int MAX_BATCHES = ibg_pkg::MaxBatchesDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire ibg_pkg::req_t request,
	output logic busy,
	output logic strobe,
	output ibg_pkg::res_t result
);
	import ibg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	ibg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .action(request.action),
		.sts(sts), .cmd(cmd), .busy(busy), .strobe(strobe)
	);

	// table and arithmetic
	ibg_datapath #(.MAX_BATCHES(MAX_BATCHES)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(request), .cmd(cmd), .sts(sts), .res(result)
	);
endmodule
`default_nettype wire

// ===== hdl/ibg_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibg_datapath: batch table, key scan, distance unit and sorter
// Holds the batch table in memories, scans it one entry a cycle for a key
// match, computes squared distances one batch per cycle and runs a stable
// insertion sort over an index permutation, one compare a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ibg_datapath #(
	parameter int MAX_BATCHES = ibg_pkg::MaxBatchesDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ibg_pkg::req_t req,
	input wire ibg_pkg::cmd_t cmd,
	output ibg_pkg::sts_t sts,
	output ibg_pkg::res_t res
);
	import ibg_pkg::*;

	localparam int IW = $clog2(MAX_BATCHES);
	localparam int CW = $clog2(MAX_BATCHES + 1);
	localparam logic [CW-1:0] NMAX = CW'(MAX_BATCHES);

	// table memories, indexed by physical slot
	logic [15:0] mesh_mem [MAX_BATCHES];
	logic [15:0] mat_mem [MAX_BATCHES];
	logic [15:0] cnt_mem [MAX_BATCHES];
	logic [71:0] pos_mem [MAX_BATCHES];
	logic [51:0] dist_mem [MAX_BATCHES];
	// permutation: logical position -> physical slot
	logic [IW-1:0] perm_q [MAX_BATCHES];

	req_t req_q;
	logic [CW-1:0] used_q;
	logic [19:0] total_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [IW-1:0] v_q;
	logic [51:0] dv_q;
	logic [51:0] dprev_q;
	logic hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [15:0] hit_cnt_q;
	logic [15:0] rd_mesh_q, rd_mat_q, rd_cnt_q;
	logic [51:0] rd_dist_q;
	res_t res_q;
	res_t res_d;
	logic [IW-1:0] p_idx;
	logic [71:0] p_rd_s1;
	logic [CW-1:0] d_idx_s1;
	logic d_vld_s1;
	logic signed [24:0] dx_s2, dy_s2, dz_s2;
	logic [CW-1:0] d_idx_s2;
	logic d_vld_s2;
	logic [49:0] sx_s3, sy_s3, sz_s3;
	logic [CW-1:0] d_idx_s3;
	logic d_vld_s3;
	logic [IW-1:0] slot;
	logic [19:0] total_inc;
	logic shift;

	assign total_inc = (total_q == TotalMax) ? total_q : total_q + 20'd1;
	assign slot = perm_q[idx_q[IW-1:0]];

	// capture request, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			total_q <= '0;
		end else if (cmd.load && req.action == ACT_CLEAR) begin
			used_q <= '0;
			total_q <= '0;
		end else if (cmd.add_finish && req_q.mesh_id != 16'd0) begin
			if (hit_q) begin
				total_q <= total_inc;
			end else if (used_q != NMAX) begin
				used_q <= used_q + CW'(1);
				total_q <= total_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// key scan over logical positions
	always_ff @(posedge clk) begin
		if (cmd.scan_clr) begin
			idx_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (mesh_mem[slot] == req_q.mesh_id && mat_mem[slot] == req_q.material_id) begin
				hit_q <= 1'b1;
				hit_idx_q <= idx_q[IW-1:0];
				hit_cnt_q <= cnt_mem[slot];
			end
			idx_q <= idx_q + CW'(1);
		end else if (cmd.dist_clr || cmd.emit_clr) begin
			idx_q <= '0;
		end else if (cmd.dist_step || cmd.emit_rd) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	assign sts.scan_done = hit_q || (idx_q >= used_q);
	assign sts.table_empty = (used_q == '0);
	assign sts.single = (req_q.action != ACT_ADD) || (req_q.mesh_id == 16'd0);

	// table writes on add of a new key, count bump on hit
	always_ff @(posedge clk) begin
		if (cmd.add_finish && req_q.mesh_id != 16'd0) begin
			if (hit_q) begin
				if (hit_cnt_q != CountMax) begin
					cnt_mem[perm_q[hit_idx_q]] <= hit_cnt_q + 16'd1;
				end
			end else if (used_q != NMAX) begin
				mesh_mem[used_q[IW-1:0]] <= req_q.mesh_id;
				mat_mem[used_q[IW-1:0]] <= req_q.material_id;
				cnt_mem[used_q[IW-1:0]] <= 16'd1;
				pos_mem[used_q[IW-1:0]] <= {req_q.pos_x, req_q.pos_y, req_q.pos_z};
			end
		end
	end

	// shift while the previous entry is strictly farther
	assign shift = (j_q != '0) && (dprev_q > dv_q);
	assign sts.shift = shift;

	// permutation: new batch lands at its own slot, sort moves entries
	always_ff @(posedge clk) begin
		if (cmd.add_finish && !hit_q && req_q.mesh_id != 16'd0 && used_q != NMAX) begin
			perm_q[used_q[IW-1:0]] <= used_q[IW-1:0];
		end else if (cmd.sort_cmp) begin
			if (shift) begin
				perm_q[j_q[IW-1:0]] <= perm_q[j_q[IW-1:0] - IW'(1)];
			end else begin
				perm_q[j_q[IW-1:0]] <= v_q;
			end
		end
	end

	// distance pipeline: read position, subtract, square, add
	assign p_idx = perm_q[idx_q[IW-1:0]];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_vld_s1 <= 1'b0;
			d_vld_s2 <= 1'b0;
			d_vld_s3 <= 1'b0;
		end else begin
			d_vld_s1 <= cmd.dist_step;
			d_vld_s2 <= d_vld_s1;
			d_vld_s3 <= d_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_rd_s1 <= pos_mem[p_idx];
		d_idx_s1 <= CW'(p_idx);
		dx_s2 <= 25'(signed'(p_rd_s1[71:48])) - 25'(req_q.cam_x);
		dy_s2 <= 25'(signed'(p_rd_s1[47:24])) - 25'(req_q.cam_y);
		dz_s2 <= 25'(signed'(p_rd_s1[23:0])) - 25'(req_q.cam_z);
		d_idx_s2 <= d_idx_s1;
		sx_s3 <= 50'(dx_s2 * dx_s2);
		sy_s3 <= 50'(dy_s2 * dy_s2);
		sz_s3 <= 50'(dz_s2 * dz_s2);
		d_idx_s3 <= d_idx_s2;
		if (d_vld_s3) begin
			dist_mem[d_idx_s3[IW-1:0]] <= 52'(sx_s3) + 52'(sy_s3) + 52'(sz_s3);
		end
	end

	assign sts.dist_done = (idx_q >= used_q);

	// insertion sort over permutation, one compare per cycle
	always_ff @(posedge clk) begin
		if (cmd.sort_clr) begin
			i_q <= CW'(1);
			j_q <= CW'(1);
		end else if (cmd.sort_rd) begin
			v_q <= perm_q[i_q[IW-1:0]];
			dv_q <= dist_mem[perm_q[i_q[IW-1:0]]];
			dprev_q <= dist_mem[perm_q[i_q[IW-1:0] - IW'(1)]];
			j_q <= i_q;
		end else if (cmd.sort_cmp) begin
			if (shift) begin
				j_q <= j_q - CW'(1);
				if (j_q > CW'(1)) begin
					dprev_q <= dist_mem[perm_q[j_q[IW-1:0] - IW'(2)]];
				end
			end else begin
				i_q <= i_q + CW'(1);
			end
		end
	end

	// sort_done: every batch has been inserted
	assign sts.sort_done = (i_q >= used_q);

	// emit read stage
	always_ff @(posedge clk) begin
		if (cmd.emit_rd) begin
			rd_mesh_q <= mesh_mem[slot];
			rd_mat_q <= mat_mem[slot];
			rd_cnt_q <= cnt_mem[slot];
			rd_dist_q <= dist_mem[slot];
		end
	end

	assign sts.emit_done = (idx_q >= used_q) || (int'(idx_q) >= ResultLimit);

	// build the next result
	always_comb begin
		res_d = '0;
		res_d.total_instances = total_q;
		res_d.last = 1'b1;
		if (cmd.single_out) begin
			if (req_q.action == ACT_CLEAR) begin
				res_d.status = ST_CLEARED;
				res_d.total_instances = '0;
			end else if (req_q.action == ACT_SORT) begin
				res_d.status = ST_EMPTY;
			end else if (req_q.mesh_id == 16'd0) begin
				res_d.status = ST_NULL;
				res_d.batch_mesh = req_q.mesh_id;
				res_d.batch_material = req_q.material_id;
			end
		end else if (cmd.add_finish) begin
			res_d.batch_mesh = req_q.mesh_id;
			res_d.batch_material = req_q.material_id;
			res_d.total_instances = total_inc;
			if (hit_q) begin
				res_d.status = ST_APPEND;
				res_d.batch_index = 6'(hit_idx_q);
				res_d.instance_count = (hit_cnt_q == CountMax) ? hit_cnt_q
					: hit_cnt_q + 16'd1;
			end else if (used_q != NMAX) begin
				res_d.status = ST_NEW;
				res_d.batch_index = 6'(used_q);
				res_d.instance_count = 16'd1;
			end else begin
				res_d.status = ST_FULL;
				res_d.total_instances = total_q;
			end
		end else if (cmd.emit_out) begin
			res_d.status = ST_SORTED;
			res_d.batch_index = 6'(idx_q - CW'(1));
			res_d.batch_mesh = rd_mesh_q;
			res_d.batch_material = rd_mat_q;
			res_d.instance_count = rd_cnt_q;
			res_d.distance_sq = rd_dist_q;
			res_d.last = sts.emit_done;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign res = res_q;

	`ASSERT_IMPL(a_used_bound, clk, arst_n, 1'b1, used_q <= NMAX)
	`ASSERT_NEXT(a_clear_zero, clk, arst_n, cmd.load && req.action == ACT_CLEAR,
		used_q == '0 && total_q == '0)
	`ASSERT_IMPL(a_emit_nonempty, clk, arst_n, cmd.emit_rd, used_q != '0)
endmodule
`default_nettype wire

// ===== hdl/ibg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibg_ctrl: sequencer for add, sort and clear requests
// Walks the datapath through scan, distance, sort and emit phases.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ibg_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [1:0] action,
	input wire ibg_pkg::sts_t sts,
	output ibg_pkg::cmd_t cmd,
	output logic busy,
	output logic strobe
);
	import ibg_pkg::*;

	state_t state_q, state_d;
	logic strobe_q;
	logic [1:0] dwait_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			strobe_q <= 1'b0;
			dwait_q <= '0;
		end else begin
			state_q <= state_d;
			strobe_q <= cmd.single_out || cmd.add_finish || cmd.emit_out;
			dwait_q <= (state_q == S_DIST_WAIT) ? dwait_q + 2'd1 : 2'd0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && action == ACT_ADD) begin
					state_d = S_SCAN;
				end else if (start && action == ACT_SORT) begin
					state_d = S_DIST;
				end else if (start && action == ACT_CLEAR) begin
					state_d = S_ADD_END;
				end
			end
			S_SCAN: begin
				if (sts.single || sts.scan_done) begin
					state_d = S_ADD_END;
				end
			end
			S_ADD_END: state_d = S_IDLE;
			S_DIST: begin
				if (sts.single && sts.table_empty) begin
					state_d = S_ADD_END;
				end else if (sts.dist_done) begin
					state_d = S_DIST_WAIT;
				end
			end
			S_DIST_WAIT: begin
				if (dwait_q == 2'd3) begin
					state_d = S_SORT_RD;
				end
			end
			S_SORT_RD: state_d = sts.sort_done ? S_EMIT_RD : S_SORT_CMP;
			S_SORT_CMP: state_d = sts.shift ? S_SORT_CMP : S_SORT_RD;
			S_EMIT_RD: state_d = S_EMIT;
			S_EMIT: state_d = sts.emit_done ? S_IDLE : S_EMIT_RD;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				cmd.scan_clr = start;
				cmd.dist_clr = start;
			end
			S_SCAN: cmd.scan_step = !(sts.single || sts.scan_done);
			S_ADD_END: begin
				cmd.single_out = sts.single;
				cmd.add_finish = !sts.single;
			end
			S_DIST: cmd.dist_step = !sts.dist_done && !sts.table_empty;
			S_DIST_WAIT: cmd.sort_clr = (dwait_q == 2'd3);
			S_SORT_RD: begin
				cmd.sort_rd = !sts.sort_done;
				cmd.emit_clr = sts.sort_done;
			end
			S_SORT_CMP: cmd.sort_cmp = 1'b1;
			S_EMIT_RD: cmd.emit_rd = 1'b1;
			S_EMIT: cmd.emit_out = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign strobe = strobe_q;

	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy && action != ACT_NOP, busy)
	`ASSERT_IMPL(a_one_cmd, clk, arst_n, 1'b1,
		$onehot0({cmd.single_out, cmd.add_finish, cmd.emit_out}))
	`ASSERT_IMPL(a_idle_quiet, clk, arst_n, state_q == S_IDLE, !cmd.emit_out)
endmodule
`default_nettype wire
